// ===== sv/tlfs_pkg.sv =====
// ----------------------------------------------------------------------------
// tlfs_pkg
// Shared types and codes for the text line fragment splitter.
// ----------------------------------------------------------------------------
package tlfs_pkg;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam logic [2:0] KIND_HEADER      = 3'd0;
    localparam logic [2:0] KIND_BODY_HDR    = 3'd1;
    localparam logic [2:0] KIND_HEADER_ONLY = 3'd2;
    localparam logic [2:0] KIND_BODY        = 3'd3;
    localparam logic [2:0] KIND_ERROR       = 3'd4;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_SHORT_HDR = 2'd1;
    localparam logic [1:0] ERR_HDR_LIMIT = 2'd2;

    localparam logic [2:0] REG_LINES_PER_FRAG = 3'd0;
    localparam logic [2:0] REG_MAX_FRAG_BYTES = 3'd1;
    localparam logic [2:0] REG_HEADER_LINES   = 3'd2;
    localparam logic [2:0] REG_MARKER_BYTES   = 3'd3;
    localparam logic [2:0] REG_MARKER_LENGTH  = 3'd4;
    localparam logic [2:0] REG_TRIM           = 3'd5;

    typedef enum logic [1:0] {
        HM_NONE   = 2'd0,
        HM_COUNT  = 2'd1,
        HM_MARKER = 2'd2
    } t_hmode;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] start_offset;
        logic [31:0] byte_length;
        logic [31:0] text_lines;
        logic [1:0]  error_code;
        logic        last_result;
    } t_out;

    typedef struct packed {
        logic [15:0] lines_per_fragment;
        logic [31:0] max_fragment_bytes;
        logic [7:0]  header_lines;
        logic [63:0] marker_bytes;
        logic [3:0]  marker_length;
        logic        trim_trailing_newlines;
    } t_cfg;

    // One finished line, or the end of the stream, as seen by the back end.
    typedef struct packed {
        logic        is_end;
        logic [63:0] size;
        logic [1:0]  ending;
        logic        match;
        t_hmode      hmode;
    } t_event;

    function automatic logic [31:0] low32(input logic [63:0] v);
        return v[31:0];
    endfunction

endpackage

// ===== sv/tlfs_fifo.sv =====
// ----------------------------------------------------------------------------
// tlfs_fifo
// Small register-based first-in first-out queue.
// ----------------------------------------------------------------------------
module tlfs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== sv/tlfs_front.sv =====
// ----------------------------------------------------------------------------
// tlfs_front
// Scans bytes, finds line endings and marker prefixes, and queues one
// event per finished line or stream end.
// ----------------------------------------------------------------------------
module tlfs_front import tlfs_pkg::*; #(
    parameter int MARKER_MAX  = 8,
    parameter int OFFSET_BITS = 32
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_valid,
    input  t_in    i_item,
    output logic   o_ev_push,
    output t_event o_ev
);
    logic [OFFSET_BITS-1:0] r_len, n_len, len_inc;
    logic                   r_cr, r_match, r_new, r_hm_valid;
    t_hmode                 r_hmode, cur_mode;
    logic [3:0]             ml;
    logic                   byte_ok, is_lf, match_now;
    logic [7:0]             mk_byte;

    assign ml      = (i_cfg.marker_length > 4'(MARKER_MAX)) ? 4'(MARKER_MAX)
                                                            : i_cfg.marker_length;
    assign mk_byte = i_cfg.marker_bytes[r_len[2:0]*8 +: 8];
    assign byte_ok = !((r_len < OFFSET_BITS'(ml)) && (i_item.data_byte != mk_byte));
    assign len_inc = r_len + 1'b1;
    assign is_lf   = (i_item.data_byte == CH_LF);

    always_comb begin
        if (r_new || !r_hm_valid) begin
            if (i_cfg.header_lines != '0)       cur_mode = HM_COUNT;
            else if (i_cfg.marker_length != '0) cur_mode = HM_MARKER;
            else                                cur_mode = HM_NONE;
        end else begin
            cur_mode = r_hmode;
        end
    end

    always_comb begin
        n_len     = r_len;
        o_ev_push = 1'b0;
        o_ev      = '0;
        o_ev.hmode = cur_mode;
        match_now = r_match && byte_ok;
        if (i_item.stream_end) begin
            o_ev_push   = i_valid;
            o_ev.is_end = 1'b1;
            o_ev.size   = 64'(r_len);
            o_ev.match  = r_match && (r_len >= OFFSET_BITS'(ml));
        end else begin
            n_len = len_inc;
            if (is_lf) begin
                o_ev_push   = i_valid;
                o_ev.size   = 64'(len_inc);
                o_ev.ending = (r_cr && len_inc >= OFFSET_BITS'(2)) ? 2'd2 : 2'd1;
                o_ev.match  = match_now && (len_inc >= OFFSET_BITS'(ml));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_cr       <= 1'b0;
            r_match    <= 1'b1;
            r_new      <= 1'b1;
            r_hm_valid <= 1'b0;
            r_hmode    <= HM_NONE;
        end else if (i_valid) begin
            if (i_item.stream_end) begin
                r_len   <= '0;
                r_cr    <= 1'b0;
                r_match <= 1'b1;
                r_new   <= 1'b1;
            end else begin
                r_new      <= 1'b0;
                r_hm_valid <= 1'b1;
                r_hmode    <= cur_mode;
                r_cr       <= (i_item.data_byte == CH_CR);
                if (is_lf) begin
                    r_len   <= '0;
                    r_match <= 1'b1;
                end else begin
                    r_len   <= n_len;
                    r_match <= match_now;
                end
            end
        end
    end

endmodule

// ===== sv/tlfs_back.sv =====
// ----------------------------------------------------------------------------
// tlfs_back
// Step sequencer that turns line events into header, fragment and error
// descriptors, one descriptor step per cycle while the result queue is not full.
// ----------------------------------------------------------------------------
module tlfs_back import tlfs_pkg::*; #(
    parameter int OFFSET_BITS = 32
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  t_event i_ev,
    input  logic   i_ev_empty,
    output logic   o_ev_pop,
    input  logic   i_out_full,
    output logic   o_out_push,
    output t_out   o_out
);
    localparam int OB = OFFSET_BITS;
    localparam int XW = (OFFSET_BITS + 2 > 33) ? OFFSET_BITS + 2 : 33;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LINE  = 7'b0000010,
        S_BODY1 = 7'b0000100,
        S_BODY2 = 7'b0001000,
        S_END2  = 7'b0010000,
        S_END3  = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    typedef enum logic [3:0] {
        PH_NEW    = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_BODY   = 4'b0100,
        PH_FAILED = 4'b1000
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    t_hmode r_hmode, n_hmode;

    logic [OB-1:0] r_s, r_e;
    logic          r_match, r_is_end;
    logic [7:0]    r_seen, n_seen, seen_inc;
    logic [OB-1:0] r_hsize, r_hend, r_htext, n_hsize, n_hend, n_htext;
    logic [OB-1:0] r_fsize, r_fend, r_ftext, r_fstart;
    logic [OB-1:0] n_fsize, n_fend, n_ftext, n_fstart;
    logic [15:0]   r_taken, n_taken, taken_inc;
    t_out          r_pend, n_pend;
    logic          r_pend_v, n_pend_v;

    logic          step;
    logic [OB-1:0] ha_size, ha_end, ha_text, fa_size, fa_end, fa_text;
    logic          exc_hdr, exc_frag;

    // Fragment emit logic and its inputs.
    logic          em_sel_add;
    logic [OB-1:0] em_size, em_end, em_text, em_trim, em_len, em_htrim;
    logic          em_valid;
    t_out          em_res;

    t_out          prod;
    logic          prod_v;
    logic          done_fin;

    function automatic logic over_limit(input logic [OB-1:0] base,
                                        input logic [OB-1:0] s,
                                        input logic [OB-1:0] extra,
                                        input logic [31:0]   maxb);
        logic [XW-1:0] sum;
        sum = XW'(base) + XW'(s) + XW'(extra);
        return (maxb != '0) && (sum > XW'(maxb));
    endfunction

    function automatic t_out mk_res(input logic [2:0] kind, input logic [OB-1:0] off,
                                    input logic [OB-1:0] len, input logic [OB-1:0] lines,
                                    input logic [1:0] err);
        t_out r;
        r.kind         = kind;
        r.start_offset = low32(64'(off));
        r.byte_length  = low32(64'(len));
        r.text_lines   = low32(64'(lines));
        r.error_code   = err;
        r.last_result  = 1'b0;
        return r;
    endfunction

    assign step      = !i_out_full;
    assign seen_inc  = r_seen + 1'b1;
    assign taken_inc = (r_taken == 16'hFFFF) ? r_taken : r_taken + 1'b1;

    // Header and fragment totals with the current line added.
    always_comb begin
        ha_size = r_hsize + r_s;
        fa_size = r_fsize + r_s;
        if (r_s == r_e) begin
            ha_end  = r_hend + r_e;
            ha_text = r_htext;
            fa_end  = r_fend + r_e;
            fa_text = r_ftext;
        end else begin
            ha_end  = r_e;
            ha_text = r_htext + 1'b1;
            fa_end  = r_e;
            fa_text = r_ftext + 1'b1;
        end
    end

    assign exc_hdr  = over_limit(r_hsize, r_s, '0, i_cfg.max_fragment_bytes);
    assign exc_frag = over_limit(r_fsize, r_s, r_hsize, i_cfg.max_fragment_bytes);

    assign em_sel_add = (r_state == S_BODY2);
    assign em_size    = em_sel_add ? fa_size : r_fsize;
    assign em_end     = em_sel_add ? fa_end  : r_fend;
    assign em_text    = em_sel_add ? fa_text : r_ftext;

    always_comb begin
        em_trim  = i_cfg.trim_trailing_newlines ? em_end : '0;
        if (em_trim > em_size) em_trim = em_size;
        em_len   = em_size - em_trim;
        em_htrim = (r_hend > r_hsize) ? r_hsize : r_hend;
        em_valid = 1'b1;
        if (r_hmode != HM_NONE) begin
            if (em_len == '0) begin
                em_res = mk_res(KIND_HEADER_ONLY, '0, r_hsize - em_htrim, '0, ERR_NONE);
            end else begin
                em_res = mk_res(KIND_BODY_HDR, r_fstart, em_len, em_text, ERR_NONE);
            end
        end else begin
            em_valid = (em_len != '0);
            em_res   = mk_res(KIND_BODY, r_fstart, em_len, em_text, ERR_NONE);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_hmode  = r_hmode;
        n_seen   = r_seen;
        n_hsize  = r_hsize;
        n_hend   = r_hend;
        n_htext  = r_htext;
        n_fsize  = r_fsize;
        n_fend   = r_fend;
        n_ftext  = r_ftext;
        n_fstart = r_fstart;
        n_taken  = r_taken;
        prod     = em_res;
        prod_v   = 1'b0;
        done_fin = 1'b0;
        o_ev_pop = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_ev_empty) begin
                    // The event leaves the queue only when the step is taken.
                    o_ev_pop = step;
                    if (r_phase == PH_NEW) begin
                        n_hmode = i_ev.hmode;
                        n_phase = (i_ev.hmode == HM_NONE) ? PH_BODY : PH_HEADER;
                    end
                    if (i_ev.is_end && (r_phase == PH_FAILED || OB'(i_ev.size) == '0)) begin
                        n_state = S_END2;
                    end else begin
                        n_state = S_LINE;
                    end
                end
            end
            S_LINE: begin
                n_state = r_is_end ? S_END2 : S_FIN;
                if (r_phase == PH_HEADER) begin
                    if (r_hmode == HM_MARKER && !r_match) begin
                        prod     = mk_res(KIND_HEADER, '0, r_hsize, r_htext, ERR_NONE);
                        prod_v   = 1'b1;
                        n_phase  = PH_BODY;
                        n_fstart = r_hsize;
                        n_state  = S_BODY1;
                    end else if (exc_hdr) begin
                        prod    = mk_res(KIND_ERROR, '0, '0, '0, ERR_HDR_LIMIT);
                        prod_v  = 1'b1;
                        n_phase = PH_FAILED;
                    end else begin
                        n_hsize = ha_size;
                        n_hend  = ha_end;
                        n_htext = ha_text;
                        if (r_hmode == HM_COUNT) begin
                            n_seen = seen_inc;
                            if (seen_inc >= i_cfg.header_lines) begin
                                prod     = mk_res(KIND_HEADER, '0, ha_size, ha_text, ERR_NONE);
                                prod_v   = 1'b1;
                                n_phase  = PH_BODY;
                                n_fstart = ha_size;
                            end
                        end
                    end
                end else if (r_phase == PH_BODY) begin
                    n_state = S_BODY1;
                end
            end
            S_BODY1: begin
                n_state = S_BODY2;
                if (r_taken != '0 && exc_frag) begin
                    prod_v   = em_valid;
                    n_fstart = r_fstart + r_fsize;
                    n_fsize  = '0;
                    n_fend   = '0;
                    n_ftext  = '0;
                    n_taken  = '0;
                end
            end
            S_BODY2: begin
                n_state = r_is_end ? S_END2 : S_FIN;
                if (exc_frag || i_cfg.lines_per_fragment == taken_inc) begin
                    // The line joins the fragment, which then closes.
                    prod_v   = em_valid;
                    n_fstart = r_fstart + fa_size;
                    n_fsize  = '0;
                    n_fend   = '0;
                    n_ftext  = '0;
                    n_taken  = '0;
                end else begin
                    n_taken = taken_inc;
                    n_fsize = fa_size;
                    n_fend  = fa_end;
                    n_ftext = fa_text;
                end
            end
            S_END2: begin
                n_state = S_END3;
                if (r_phase == PH_HEADER) begin
                    if (r_hmode == HM_COUNT && r_seen < i_cfg.header_lines) begin
                        prod    = mk_res(KIND_ERROR, '0, '0, '0, ERR_SHORT_HDR);
                        prod_v  = 1'b1;
                        n_phase = PH_FAILED;
                    end else begin
                        prod     = mk_res(KIND_HEADER, '0, r_hsize, r_htext, ERR_NONE);
                        prod_v   = 1'b1;
                        n_phase  = PH_BODY;
                        n_fstart = r_hsize;
                    end
                end
            end
            S_END3: begin
                n_state = S_FIN;
                if (r_phase == PH_BODY && r_fsize != '0) begin
                    prod_v = em_valid;
                end
                // The stream is over: the phase and the header and fragment state return to their start values.
                n_phase  = PH_NEW;
                n_hmode  = HM_NONE;
                n_seen   = '0;
                n_hsize  = '0;
                n_hend   = '0;
                n_htext  = '0;
                n_fsize  = '0;
                n_fend   = '0;
                n_ftext  = '0;
                n_fstart = '0;
                n_taken  = '0;
            end
            S_FIN: begin
                n_state  = S_IDLE;
                done_fin = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The newest result waits in a holding register until the next one, or
    // the end of the event, tells whether it is the last one.
    always_comb begin
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        o_out_push = 1'b0;
        o_out      = r_pend;
        if (done_fin) begin
            o_out.last_result = 1'b1;
            o_out_push        = r_pend_v;
            n_pend_v          = 1'b0;
        end else if (prod_v) begin
            o_out_push = r_pend_v;
            n_pend     = prod;
            n_pend_v   = 1'b1;
        end
        if (!step) begin
            o_out_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_NEW;
            r_hmode  <= HM_NONE;
            r_seen   <= '0;
            r_hsize  <= '0;
            r_hend   <= '0;
            r_htext  <= '0;
            r_fsize  <= '0;
            r_fend   <= '0;
            r_ftext  <= '0;
            r_fstart <= '0;
            r_taken  <= '0;
            r_pend_v <= 1'b0;
        end else if (step) begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_hmode  <= n_hmode;
            r_seen   <= n_seen;
            r_hsize  <= n_hsize;
            r_hend   <= n_hend;
            r_htext  <= n_htext;
            r_fsize  <= n_fsize;
            r_fend   <= n_fend;
            r_ftext  <= n_ftext;
            r_fstart <= n_fstart;
            r_taken  <= n_taken;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_pend <= n_pend;
            if (o_ev_pop) begin
                r_s      <= OB'(i_ev.size);
                r_e      <= OB'(i_ev.ending);
                r_match  <= i_ev.match;
                r_is_end <= i_ev.is_end;
            end
        end
    end

    a_err_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push && o_out.kind == KIND_ERROR |->
            o_out.start_offset == '0 && o_out.byte_length == '0 && o_out.text_lines == '0)
        else $error("error result carries nonzero range fields");

    a_no_code_on_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push && o_out.kind != KIND_ERROR |-> o_out.error_code == ERR_NONE)
        else $error("normal result carries an error code");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_pend_v)
        else $error("result left pending between events");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ev_pop && step |=> r_state == S_LINE || r_state == S_END2)
        else $error("event taken without starting its steps");

endmodule

// ===== sv/text_line_fragment_splitter_top.sv =====
// Throughput: one byte per cycle while full is low; the back-end sequencer steps through its
// states for each line or stream end, so short lines fill the event queue and raise full.
// Results leave through a four-entry queue, at most one per cycle.
// Reset (synchronous, active low) clears the queues, the registers to their
// reset values and the line and fragment state; no clearing pass is needed.
// ----------------------------------------------------------------------------
// text_line_fragment_splitter_top
// Splits a byte stream into header and line-count or size-bounded fragments, with error results.
// ----------------------------------------------------------------------------
module text_line_fragment_splitter_top import tlfs_pkg::*; #(
    parameter int MARKER_MAX  = 8,
    parameter int OFFSET_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in         i_item,
    output logic        empty,
    input  logic        pop,
    output t_out        o_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    t_cfg   r_cfg;
    logic   in_acc, ev_push, ev_full, ev_empty, ev_pop, out_full, out_push;
    t_event ev_in, ev_out;
    t_out   res;
    logic [$bits(t_event)-1:0] ev_raw;
    logic [$bits(t_out)-1:0]   out_raw;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign full    = ev_full;
    assign in_acc  = push && !ev_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lines_per_fragment     <= 16'd1;
            r_cfg.max_fragment_bytes     <= '0;
            r_cfg.header_lines           <= '0;
            r_cfg.marker_bytes           <= '0;
            r_cfg.marker_length          <= '0;
            r_cfg.trim_trailing_newlines <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_LINES_PER_FRAG: r_cfg.lines_per_fragment     <= pwdata[15:0];
                REG_MAX_FRAG_BYTES: r_cfg.max_fragment_bytes     <= pwdata[31:0];
                REG_HEADER_LINES:   r_cfg.header_lines           <= pwdata[7:0];
                REG_MARKER_BYTES:   r_cfg.marker_bytes           <= pwdata;
                REG_MARKER_LENGTH:  r_cfg.marker_length          <= pwdata[3:0];
                REG_TRIM:           r_cfg.trim_trailing_newlines <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LINES_PER_FRAG: prdata = 64'(r_cfg.lines_per_fragment);
            REG_MAX_FRAG_BYTES: prdata = 64'(r_cfg.max_fragment_bytes);
            REG_HEADER_LINES:   prdata = 64'(r_cfg.header_lines);
            REG_MARKER_BYTES:   prdata = r_cfg.marker_bytes;
            REG_MARKER_LENGTH:  prdata = 64'(r_cfg.marker_length);
            REG_TRIM:           prdata = 64'(r_cfg.trim_trailing_newlines);
            default:            prdata = '0;
        endcase
    end

    tlfs_front #(.MARKER_MAX(MARKER_MAX), .OFFSET_BITS(OFFSET_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (in_acc),
        .i_item    (i_item),
        .o_ev_push (ev_push),
        .o_ev      (ev_in)
    );

    tlfs_fifo #(.WIDTH($bits(t_event)), .DEPTH(4)) u_ev_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ev_push),
        .i_data  (ev_in),
        .o_full  (ev_full),
        .i_pop   (ev_pop),
        .o_data  (ev_raw),
        .o_empty (ev_empty)
    );

    assign ev_out = t_event'(ev_raw);

    tlfs_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_ev       (ev_out),
        .i_ev_empty (ev_empty),
        .o_ev_pop   (ev_pop),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_out      (res)
    );

    tlfs_fifo #(.WIDTH($bits(t_out)), .DEPTH(4)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_raw),
        .o_empty (empty)
    );

    assign o_item = t_out'(out_raw);

endmodule
